### hdl/dts_pkg.sv
// Shared types and constants for the dab tile segment splitter.
// Used by every module of the block and by its checker; no dependencies.
package dts_pkg;

  // Tile geometry and limits
  localparam int unsigned TILE_SIZE    = 64;
  localparam int unsigned TS_W         = $clog2(TILE_SIZE);
  localparam int unsigned MAX_DIAMETER = 255;
  localparam int unsigned MAX_RESULTS  = 25;
  localparam int unsigned CNT_W        = $clog2(MAX_RESULTS);
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Field widths
  localparam int unsigned COORD_W = 15;              // signed dab corner
  localparam int unsigned DIA_W   = 8;
  localparam int unsigned DIM_W   = 15;              // layer width / height
  localparam int unsigned TPR_W   = 9;
  localparam int unsigned POS_W   = 16;              // clipped pixel position
  localparam int unsigned TC_W    = POS_W - 1 - TS_W; // tile column / row
  localparam int unsigned OFS_W   = DIA_W + 1;       // offset into the mask
  localparam int unsigned SEG_W   = TS_W + 1;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned MOFF_W  = 16;
  localparam int unsigned CFG_W   = 15;

  // Stream packing: input tdata
  localparam int unsigned IN_LEFT_LSB = 0;
  localparam int unsigned IN_TOP_LSB  = IN_LEFT_LSB + COORD_W;
  localparam int unsigned IN_DIA_LSB  = IN_TOP_LSB + COORD_W;
  localparam int unsigned IN_BITS     = IN_DIA_LSB + DIA_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Stream packing: output tdata
  localparam int unsigned OUT_IDX_LSB  = 0;
  localparam int unsigned OUT_X_LSB    = OUT_IDX_LSB + IDX_W;
  localparam int unsigned OUT_Y_LSB    = OUT_X_LSB + TS_W;
  localparam int unsigned OUT_W_LSB    = OUT_Y_LSB + TS_W;
  localparam int unsigned OUT_H_LSB    = OUT_W_LSB + SEG_W;
  localparam int unsigned OUT_MOFF_LSB = OUT_H_LSB + SEG_W;
  localparam int unsigned OUT_SKIP_LSB = OUT_MOFF_LSB + MOFF_W;
  localparam int unsigned OUT_BITS     = OUT_SKIP_LSB + DIA_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CFG_LAYER_WIDTH   = 2'd0,
    CFG_LAYER_HEIGHT  = 2'd1,
    CFG_TILES_PER_ROW = 2'd2
  } cfg_idx_e;

  // Clipped footprint of one dab, handed from front to back
  typedef struct packed {
    logic [POS_W-1:0] y0;
    logic [POS_W-1:0] x0;
    logic [OFS_W-1:0] yb0;
    logic [OFS_W-1:0] xb0;
    logic [POS_W-1:0] bottom;
    logic [POS_W-1:0] right;
    logic [DIA_W-1:0] dia;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]  tile_index;
    logic [TS_W-1:0]   x_in_tile;
    logic [TS_W-1:0]   y_in_tile;
    logic [SEG_W-1:0]  segment_width;
    logic [SEG_W-1:0]  segment_height;
    logic [MOFF_W-1:0] mask_offset;
    logic [DIA_W-1:0]  mask_row_skip;
    logic              last_segment;
  } seg_t;

endpackage

### hdl/dts_front.sv
// Front end: clips one dab against the layer and builds its job descriptor.
// Depends on dts_pkg.
module dts_front (
  input  logic [dts_pkg::COORD_W-1:0] dab_left_i,
  input  logic [dts_pkg::COORD_W-1:0] dab_top_i,
  input  logic [dts_pkg::DIA_W-1:0]   dab_diameter_i,
  input  logic [dts_pkg::DIM_W-1:0]   layer_width_i,
  input  logic [dts_pkg::DIM_W-1:0]   layer_height_i,
  output dts_pkg::job_t               job_o,
  output logic                        job_ok_o
);

  localparam int unsigned SW = dts_pkg::POS_W + 1;

  logic [dts_pkg::DIA_W-1:0] dia;
  logic signed [SW-1:0] ls, ts, dia_s, ld, td, lw_s, lh_s, neg_l, neg_t;
  logic signed [SW-1:0] bottom_s, right_s;
  logic outside;
  logic [dts_pkg::POS_W-1:0] x0, y0;

  always_comb begin
    dia = (dab_diameter_i > dts_pkg::DIA_W'(dts_pkg::MAX_DIAMETER)) ?
          dts_pkg::DIA_W'(dts_pkg::MAX_DIAMETER) : dab_diameter_i;
    ls    = {{(SW - dts_pkg::COORD_W){dab_left_i[dts_pkg::COORD_W-1]}}, dab_left_i};
    ts    = {{(SW - dts_pkg::COORD_W){dab_top_i[dts_pkg::COORD_W-1]}}, dab_top_i};
    dia_s = $signed({{(SW - dts_pkg::DIA_W){1'b0}}, dia});
    lw_s  = $signed({{(SW - dts_pkg::DIM_W){1'b0}}, layer_width_i});
    lh_s  = $signed({{(SW - dts_pkg::DIM_W){1'b0}}, layer_height_i});
    ld    = ls + dia_s;
    td    = ts + dia_s;
    neg_l = -ls;
    neg_t = -ts;

    outside = (ld <= 0) || (td <= 0) || (ls >= lw_s) || (ts >= lh_s);

    bottom_s = (td < lh_s) ? td : lh_s;
    right_s  = (ld < lw_s) ? ld : lw_s;

    x0 = ls[SW-1] ? '0 : ls[dts_pkg::POS_W-1:0];
    y0 = ts[SW-1] ? '0 : ts[dts_pkg::POS_W-1:0];

    job_o.x0     = x0;
    job_o.y0     = y0;
    job_o.xb0    = ls[SW-1] ? neg_l[dts_pkg::OFS_W-1:0] : '0;
    job_o.yb0    = ts[SW-1] ? neg_t[dts_pkg::OFS_W-1:0] : '0;
    job_o.bottom = bottom_s[dts_pkg::POS_W-1:0];
    job_o.right  = right_s[dts_pkg::POS_W-1:0];
    job_o.dia    = dia;

    // an empty footprint (zero diameter, zero-size layer) yields no job
    job_ok_o = !outside && (y0 < bottom_s[dts_pkg::POS_W-1:0]) &&
               (x0 < right_s[dts_pkg::POS_W-1:0]);
  end

endmodule

### hdl/dts_queue.sv
// Small job queue between front and back end.
// Depends on dts_pkg for the job descriptor type.
module dts_queue #(
  parameter int unsigned Depth = dts_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dts_pkg::job_t push_data_i,
  input  logic          pop_i,
  output dts_pkg::job_t pop_data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dts_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hdl/dts_back.sv
// Back end: walks a job's tiles; in its run state, if not stalled, it
// emits one segment per cycle to an output register. Needs dts_pkg.
module dts_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dts_pkg::TPR_W-1:0] tiles_per_row_i,
  input  dts_pkg::job_t             job_i,
  input  logic                      job_avail_i,
  output logic                      job_pop_o,
  output dts_pkg::seg_t             seg_o,
  output logic                      seg_valid_o,
  input  logic                      seg_ready_i
);

  localparam int unsigned POS_W = dts_pkg::POS_W;
  localparam int unsigned TS_W  = dts_pkg::TS_W;
  localparam int unsigned TC_W  = dts_pkg::TC_W;
  localparam int unsigned OFS_W = dts_pkg::OFS_W;
  localparam int unsigned SEG_W = dts_pkg::SEG_W;
  localparam int unsigned DIA_W = dts_pkg::DIA_W;
  localparam int unsigned RB_W  = dts_pkg::TPR_W + TC_W;
  localparam int unsigned MR_W  = OFS_W + DIA_W;
  localparam int unsigned SUM_W = OFS_W + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_ROW, ST_RUN} state_e;

  state_e state_q;
  logic [DIA_W-1:0] dia_q;
  logic [POS_W-1:0] x0_q, right_q, bottom_q, x_q, y_q;
  logic [OFS_W-1:0] xb0_q, xb_q, yb_q;
  logic [SEG_W-1:0] hb_q;
  logic [RB_W-1:0]  row_base_q;
  logic [MR_W-1:0]  mrow_q;
  logic [dts_pkg::CNT_W-1:0] cnt_q;
  dts_pkg::seg_t seg_q;
  logic seg_valid_q;

  logic [TS_W-1:0]  xt, yt;
  logic [TC_W-1:0]  tx, ty;
  logic [TC_W:0]    tx_inc, ty_inc;
  logic [POS_W-1:0] nx, ny;
  logic [OFS_W-1:0] rem_x, rem_y;
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [SEG_W-1:0] wb, hb;
  logic [OFS_W-1:0] skip;
  logic             last, row_end, emit;

  always_comb begin
    xt     = x_q[TS_W-1:0];
    yt     = y_q[TS_W-1:0];
    tx     = x_q[POS_W-2:TS_W];
    ty     = y_q[POS_W-2:TS_W];
    tx_inc = {1'b0, tx} + 1'b1;
    ty_inc = {1'b0, ty} + 1'b1;
    nx     = {tx_inc, {TS_W{1'b0}}};
    ny     = {ty_inc, {TS_W{1'b0}}};

    // segment extent is bounded by the tile edge or the dab edge only
    rem_x = {1'b0, dia_q} - xb_q;
    rem_y = {1'b0, dia_q} - yb_q;
    sum_x = {{(SUM_W - TS_W){1'b0}}, xt} + {1'b0, rem_x};
    sum_y = {{(SUM_W - TS_W){1'b0}}, yt} + {1'b0, rem_y};
    wb = (sum_x < SUM_W'(dts_pkg::TILE_SIZE)) ? rem_x[SEG_W-1:0] :
         SEG_W'(dts_pkg::TILE_SIZE) - {1'b0, xt};
    hb = (sum_y < SUM_W'(dts_pkg::TILE_SIZE)) ? rem_y[SEG_W-1:0] :
         SEG_W'(dts_pkg::TILE_SIZE) - {1'b0, yt};
    skip = {1'b0, dia_q} - {{(OFS_W - SEG_W){1'b0}}, wb};

    row_end = (nx >= right_q);
    last    = (cnt_q == dts_pkg::CNT_W'(dts_pkg::MAX_RESULTS - 1)) ||
              (row_end && (ny >= bottom_q));
    emit    = (state_q == ST_RUN) && (!seg_valid_q || seg_ready_i);
  end

  assign job_pop_o   = (state_q == ST_IDLE) && job_avail_i;
  assign seg_o       = seg_q;
  assign seg_valid_o = seg_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (emit) begin
        seg_valid_q <= 1'b1;
      end else if (seg_ready_i) begin
        seg_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_avail_i) begin
            dia_q    <= job_i.dia;
            x0_q     <= job_i.x0;
            xb0_q    <= job_i.xb0;
            right_q  <= job_i.right;
            bottom_q <= job_i.bottom;
            x_q      <= job_i.x0;
            xb_q     <= job_i.xb0;
            y_q      <= job_i.y0;
            yb_q     <= job_i.yb0;
            cnt_q    <= '0;
            state_q  <= ST_ROW;
          end
        end
        ST_ROW: begin
          // per-row bases for tile index and mask offset
          row_base_q <= RB_W'(tiles_per_row_i * ty);
          mrow_q     <= MR_W'(yb_q * dia_q);
          hb_q       <= hb;
          state_q    <= ST_RUN;
        end
        ST_RUN: begin
          if (emit) begin
            seg_q.tile_index     <= dts_pkg::IDX_W'(row_base_q + {{(RB_W - TC_W){1'b0}}, tx});
            seg_q.x_in_tile      <= xt;
            seg_q.y_in_tile      <= yt;
            seg_q.segment_width  <= wb;
            seg_q.segment_height <= hb_q;
            seg_q.mask_offset    <= dts_pkg::MOFF_W'(mrow_q +
                                    {{(MR_W - OFS_W){1'b0}}, xb_q});
            seg_q.mask_row_skip  <= skip[DIA_W-1:0];
            seg_q.last_segment   <= last;
            cnt_q                <= cnt_q + 1'b1;
            if (last) begin
              state_q <= ST_IDLE;
            end else if (row_end) begin
              y_q     <= ny;
              yb_q    <= yb_q + {{(OFS_W - SEG_W){1'b0}}, hb_q};
              x_q     <= x0_q;
              xb_q    <= xb0_q;
              state_q <= ST_ROW;
            end else begin
              x_q  <= nx;
              xb_q <= xb_q + {{(OFS_W - SEG_W){1'b0}}, wb};
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/dab_tile_segment_splitter.sv
// Top level of the dab tile segment splitter: configuration registers,
// stream packing, front end, job queue and back end. Depends on dts_pkg.

// Splits one square brush dab into per-tile segments over a layer of
// 64-pixel tiles, row of tiles by row, left to right; a dab outside the
// layer produces nothing and at most 25 segments are emitted per dab.
// The front end clips a request in the cycle it is accepted and queues a
// job; the back end pops the job in its idle state, sets up each tile
// row's tile index and mask offset bases (two small multipliers) in its
// row state, then emits that row's segments in its run state. The
// queue lets new requests be accepted while earlier dabs are worked off.
// Layer size and tile row count are written through the cfg port; the
// user must write them only while the block is idle, which the block
// itself does not enforce.
module dab_tile_segment_splitter #(
  parameter int unsigned QueueDepth = dts_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // cfg write port
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [dts_pkg::CFG_W-1:0]       cfg_data_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: dab_left[14:0], dab_top[29:15], dab_diameter[37:30], zero pad
  input  logic [dts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // segment stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: tile_index[15:0], x_in_tile[21:16], y_in_tile[27:22],
  //        segment_width[34:28], segment_height[41:35], mask_offset[57:42],
  //        mask_row_skip[65:58], zero pad
  output logic [dts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tlast: last_segment
  output logic                            m_axis_tlast
);

  logic [dts_pkg::DIM_W-1:0] layer_width_q, layer_height_q;
  logic [dts_pkg::TPR_W-1:0] tiles_per_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_width_q   <= dts_pkg::DIM_W'(16384);
      layer_height_q  <= dts_pkg::DIM_W'(16384);
      tiles_per_row_q <= dts_pkg::TPR_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dts_pkg::CFG_LAYER_WIDTH:   layer_width_q   <= cfg_data_i[dts_pkg::DIM_W-1:0];
        dts_pkg::CFG_LAYER_HEIGHT:  layer_height_q  <= cfg_data_i[dts_pkg::DIM_W-1:0];
        dts_pkg::CFG_TILES_PER_ROW: tiles_per_row_q <= cfg_data_i[dts_pkg::TPR_W-1:0];
        default: ;
      endcase
    end
  end

  dts_pkg::job_t job_in, job_out;
  dts_pkg::seg_t seg;
  logic job_ok, q_full, q_empty, q_pop, q_push, seg_valid;

  dts_front u_front (
    .dab_left_i     (s_axis_tdata[dts_pkg::IN_LEFT_LSB +: dts_pkg::COORD_W]),
    .dab_top_i      (s_axis_tdata[dts_pkg::IN_TOP_LSB +: dts_pkg::COORD_W]),
    .dab_diameter_i (s_axis_tdata[dts_pkg::IN_DIA_LSB +: dts_pkg::DIA_W]),
    .layer_width_i  (layer_width_q),
    .layer_height_i (layer_height_q),
    .job_o          (job_in),
    .job_ok_o       (job_ok)
  );

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && job_ok;

  dts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (job_in),
    .pop_i       (q_pop),
    .pop_data_o  (job_out),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  dts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tiles_per_row_i (tiles_per_row_q),
    .job_i           (job_out),
    .job_avail_i     (!q_empty),
    .job_pop_o       (q_pop),
    .seg_o           (seg),
    .seg_valid_o     (seg_valid),
    .seg_ready_i     (m_axis_tready)
  );

  assign m_axis_tvalid = seg_valid;
  assign m_axis_tlast  = seg.last_segment;
  assign m_axis_tdata  = {{(dts_pkg::OUT_TDATA_W - dts_pkg::OUT_BITS){1'b0}},
                          seg.mask_row_skip, seg.mask_offset, seg.segment_height,
                          seg.segment_width, seg.y_in_tile, seg.x_in_tile,
                          seg.tile_index};

endmodule

### hdl/dts_checker.sv
// Port-level checks on the segment stream of the splitter, bound to the
// top level. Depends on dts_pkg for field positions.
module dts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  localparam int unsigned TS_W  = dts_pkg::TS_W;
  localparam int unsigned SEG_W = dts_pkg::SEG_W;

  logic [TS_W-1:0]  x_in_tile, y_in_tile;
  logic [SEG_W-1:0] seg_w, seg_h;
  logic [dts_pkg::DIA_W-1:0] skip;

  assign x_in_tile = m_axis_tdata[dts_pkg::OUT_X_LSB +: TS_W];
  assign y_in_tile = m_axis_tdata[dts_pkg::OUT_Y_LSB +: TS_W];
  assign seg_w     = m_axis_tdata[dts_pkg::OUT_W_LSB +: SEG_W];
  assign seg_h     = m_axis_tdata[dts_pkg::OUT_H_LSB +: SEG_W];
  assign skip      = m_axis_tdata[dts_pkg::OUT_SKIP_LSB +: dts_pkg::DIA_W];

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("segment valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("segment payload changed while stalled");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (seg_w != '0) && (seg_h != '0) &&
                      (seg_w <= SEG_W'(dts_pkg::TILE_SIZE)) &&
                      (seg_h <= SEG_W'(dts_pkg::TILE_SIZE)))
    else $error("segment size out of range");

  a_in_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, x_in_tile} + seg_w <= SEG_W'(dts_pkg::TILE_SIZE)) &&
                      ({1'b0, y_in_tile} + seg_h <= SEG_W'(dts_pkg::TILE_SIZE)))
    else $error("segment crosses a tile edge");

  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, skip} + {{(dts_pkg::DIA_W + 1 - SEG_W){1'b0}}, seg_w}
                       <= (dts_pkg::DIA_W + 1)'(dts_pkg::MAX_DIAMETER)))
    else $error("mask row skip inconsistent with segment width");

endmodule

bind dab_tile_segment_splitter dts_checker u_dts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
